// ===== hdl/byte_stream_reassembler_macros.svh =====
// Assertion macros shared by the byte stream reassembler modules.
// Depends on nothing; included by the files that carry checks.
`ifndef BYTE_STREAM_REASSEMBLER_MACROS_SVH
`define BYTE_STREAM_REASSEMBLER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BSR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("byte_stream_reassembler: invariant violated");

// A consequence that must hold in the cycle after its trigger.
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte_stream_reassembler: sequence violated");

`endif

// ===== hdl/bsr_pkg.sv =====
// Shared types and constants of the byte stream reassembler.
// Depends on nothing; used by the interfaces and all modules.
package bsr_pkg;

    // Field widths of the request and result channels.
    localparam int IDX_W  = 64;
    localparam int BYTE_W = 8;
    localparam int ROOM_W = 7;
    localparam int CNT_W  = 7;

    // Default ring depth.
    localparam int CAPACITY_DEF = 64;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STORE,
        ST_DRAIN
    } t_bsr_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic store;
        logic emit;
    } t_bsr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic release_ok;
        logic more;
    } t_bsr_sts;

endpackage

// ===== hdl/bsr_if.sv =====
// Request and result channel interfaces of the byte stream reassembler.
// Depends on bsr_pkg for the field widths.
interface bsr_in_if;
    import bsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  stream_index;
    logic [BYTE_W-1:0] data_byte;
    logic              no_byte;
    logic              final_mark;
    logic [ROOM_W-1:0] room;

    modport source (
        output valid, stream_index, data_byte, no_byte, final_mark, room,
        input  ready
    );
    modport sink (
        input  valid, stream_index, data_byte, no_byte, final_mark, room,
        output ready
    );
endinterface

interface bsr_out_if;
    import bsr_pkg::*;

    logic              valid;
    logic              ready;
    logic              has_byte;
    logic [BYTE_W-1:0] out_byte;
    logic              last_result;
    logic              stream_closed;
    logic [CNT_W-1:0]  pending_bytes;

    modport source (
        output valid, has_byte, out_byte, last_result, stream_closed, pending_bytes,
        input  ready
    );
    modport sink (
        input  valid, has_byte, out_byte, last_result, stream_closed, pending_bytes,
        output ready
    );
endinterface

// ===== hdl/bsr_ctrl.sv =====
// Controller state machine of the byte stream reassembler.
// Depends on bsr_pkg; drives the datapath through t_bsr_cmd.
module bsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bsr_pkg::t_bsr_sts i_sts,
    output bsr_pkg::t_bsr_cmd o_cmd,
    output logic              o_in_ready
);
    import bsr_pkg::*;

    t_bsr_state r_state;
    t_bsr_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: take a request, store its byte, then release results.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_sts.out_free && !(i_sts.release_ok && i_sts.more)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/bsr_datapath.sv =====
// Datapath of the byte stream reassembler: window check, byte ring,
// slot valid marks, stream counters and the result register.
// Depends on bsr_pkg and byte_stream_reassembler_macros.svh.
`include "byte_stream_reassembler_macros.svh"

module bsr_datapath #(
    parameter int CAPACITY = bsr_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bsr_pkg::t_bsr_cmd          i_cmd,
    output bsr_pkg::t_bsr_sts          o_sts,
    input  logic [bsr_pkg::IDX_W-1:0]  i_stream_index,
    input  logic [bsr_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_no_byte,
    input  logic                       i_final_mark,
    input  logic [bsr_pkg::ROOM_W-1:0] i_room,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_has_byte,
    output logic [bsr_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last_result,
    output logic                       o_stream_closed,
    output logic [bsr_pkg::CNT_W-1:0]  o_pending_bytes
);
    import bsr_pkg::*;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W  = ROOM_W + 1;

    localparam logic [ROOM_W-1:0] CAP_ROOM = ROOM_W'(CAPACITY);
    localparam logic [SUM_W-1:0]  CAP_SUM  = SUM_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

    // Stream state.
    logic [IDX_W-1:0]    r_ne;
    logic [SLOT_W-1:0]   r_ne_slot;
    logic [IDX_W-1:0]    r_final_end;
    logic                r_final_seen;
    logic [CNT_W-1:0]    r_held;
    logic                r_closed;
    logic [CAPACITY-1:0] r_valid;

    // Byte ring and its registered read port.
    logic [BYTE_W-1:0]   r_ring [CAPACITY];
    logic [BYTE_W-1:0]   r_rd_data;

    // Request being worked on.
    logic                r_win;
    logic [ROOM_W-1:0]   r_off;
    logic [BYTE_W-1:0]   r_data;
    logic [ROOM_W-1:0]   r_room_left;

    // Result register.
    logic                r_out_valid;
    logic                r_out_has;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;
    logic                r_out_closed;
    logic [CNT_W-1:0]    r_out_pend;

    logic [ROOM_W-1:0]   room_sat;
    logic [IDX_W:0]      diff;
    logic                in_win;
    logic [SUM_W-1:0]    slot_sum;
    logic [SUM_W-1:0]    slot_wrap;
    logic [SLOT_W-1:0]   wr_slot;
    logic                wr_en;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   n_ne_slot;
    logic [IDX_W-1:0]    ne_plus;
    logic                release_ok;
    logic                more;
    logic                close_now;
    logic                close_after;

    // Window check of an incoming byte against the expected position.
    always_comb begin
        room_sat = (i_room > CAP_ROOM) ? CAP_ROOM : i_room;
        diff     = {1'b0, i_stream_index} - {1'b0, r_ne};
        in_win   = !i_no_byte && !diff[IDX_W] && (diff[IDX_W-1:ROOM_W] == '0)
                   && (diff[ROOM_W-1:0] < room_sat);
    end

    // Ring slot of the byte: expected slot plus offset, wrapped once.
    always_comb begin
        slot_sum  = SUM_W'(r_ne_slot) + SUM_W'(r_off);
        slot_wrap = (slot_sum >= CAP_SUM) ? (slot_sum - CAP_SUM) : slot_sum;
        wr_slot   = slot_wrap[SLOT_W-1:0];
        wr_en     = i_cmd.store && r_win && !r_valid[wr_slot];
    end

    // Release decisions for the slot at the expected position.
    always_comb begin
        slot_inc    = (r_ne_slot == LAST_SLOT) ? '0 : r_ne_slot + 1'b1;
        ne_plus     = r_ne + 1'b1;
        release_ok  = (r_room_left != '0) && r_valid[r_ne_slot];
        more        = (r_room_left > ROOM_W'(1)) && r_valid[slot_inc];
        close_now   = r_closed || (r_final_seen && (r_ne == r_final_end));
        close_after = r_final_seen && (ne_plus == r_final_end);
        n_ne_slot   = (i_cmd.emit && release_ok) ? slot_inc : r_ne_slot;
    end

    always_comb begin
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.release_ok = release_ok;
        o_sts.more       = more;
    end

    // Byte ring: one write port, one registered read port at the next
    // expected slot, with the same-cycle write passed through.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_slot] <= r_data;
        end
        r_rd_data <= (wr_en && (wr_slot == n_ne_slot)) ? r_data : r_ring[n_ne_slot];
    end

    // Request capture; a closed stream keeps no byte and grants no room.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_win       <= in_win && !r_closed;
            r_off       <= diff[ROOM_W-1:0];
            r_data      <= i_data_byte;
            r_room_left <= r_closed ? '0 : room_sat;
        end else if (i_cmd.emit && release_ok) begin
            r_room_left <= r_room_left - 1'b1;
        end
    end

    // Stream state: final mark, stored bytes, released bytes, closing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne         <= '0;
            r_ne_slot    <= '0;
            r_final_end  <= '0;
            r_final_seen <= 1'b0;
            r_held       <= '0;
            r_closed     <= 1'b0;
            r_valid      <= '0;
        end else begin
            if (i_cmd.accept && !r_closed && i_final_mark) begin
                r_final_end  <= i_no_byte ? i_stream_index : i_stream_index + 1'b1;
                r_final_seen <= 1'b1;
            end
            if (wr_en) begin
                r_valid[wr_slot] <= 1'b1;
                r_held           <= r_held + 1'b1;
            end
            if (i_cmd.emit) begin
                if (release_ok) begin
                    r_valid[r_ne_slot] <= 1'b0;
                    r_held             <= r_held - 1'b1;
                    r_ne               <= ne_plus;
                    r_ne_slot          <= slot_inc;
                    if (!more && close_after) begin
                        r_closed <= 1'b1;
                    end
                end else begin
                    r_closed <= close_now;
                end
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: a released byte, or one status result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (release_ok) begin
                r_out_has    <= 1'b1;
                r_out_byte   <= r_rd_data;
                r_out_last   <= !more;
                r_out_closed <= !more && close_after;
                r_out_pend   <= r_held - 1'b1;
            end else begin
                r_out_has    <= 1'b0;
                r_out_byte   <= '0;
                r_out_last   <= 1'b1;
                r_out_closed <= close_now;
                r_out_pend   <= r_held;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_has_byte      = r_out_has;
    assign o_out_byte      = r_out_byte;
    assign o_last_result   = r_out_last;
    assign o_stream_closed = r_out_closed;
    assign o_pending_bytes = r_out_pend;

    // Checks on the ring bookkeeping.
    `BSR_ASSERT_ALWAYS(a_held_matches_valid, i_clk, i_rst_n, $countones(r_valid) == r_held)
    `BSR_ASSERT_ALWAYS(a_held_in_range, i_clk, i_rst_n, r_held <= CAPACITY)
    `BSR_ASSERT_NEXT(a_closed_sticks, i_clk, i_rst_n, r_closed, r_closed)
    `BSR_ASSERT_NEXT(a_release_drops_held, i_clk, i_rst_n, i_cmd.emit && release_ok, r_held == $past(r_held) - 7'd1)

endmodule

// ===== hdl/byte_stream_reassembler.sv =====
// Byte stream reassembler. Each request carries one byte (or only a final
// mark) at an absolute stream position, with the room the downstream writer
// has now. Bytes inside the window from the next expected position up to that
// room are kept in a ring of CAPACITY bytes, first copy wins; then, while the
// room lasts, each contiguous byte from the expected position is released in
// order, one result each, or a single status result when none is released. A
// request is taken in the idle state, its byte is stored in the store state,
// and the drain state then gives one result per released byte (or the status
// result), holding while the result register is full. This pace is set by the
// single read port of the byte ring feeding the result register. The next
// request is taken once the last result of the current one sits in the result
// register.
module byte_stream_reassembler #(
    parameter int CAPACITY = bsr_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsr_in_if.sink     i_in,
    bsr_out_if.source  o_out
);
    import bsr_pkg::*;

    t_bsr_cmd cmd;
    t_bsr_sts sts;
    logic     in_ready;

    // Controller.
    bsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    assign i_in.ready = in_ready;

    // Datapath.
    bsr_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_stream_index  (i_in.stream_index),
        .i_data_byte     (i_in.data_byte),
        .i_no_byte       (i_in.no_byte),
        .i_final_mark    (i_in.final_mark),
        .i_room          (i_in.room),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_has_byte      (o_out.has_byte),
        .o_out_byte      (o_out.out_byte),
        .o_last_result   (o_out.last_result),
        .o_stream_closed (o_out.stream_closed),
        .o_pending_bytes (o_out.pending_bytes)
    );

endmodule

// ===== tb/sv/byte_stream_reassembler_tb.sv =====
// Self-checking testbench for the byte stream reassembler: a directed table, then random requests.
// Expected results come from a behavioral predictor of the reassembly ring kept in this file.
// Depends on bsr_pkg and the bsr_in_if / bsr_out_if interfaces of the RTL.
`timescale 1ns / 1ps

module byte_stream_reassembler_tb;
    import bsr_pkg::*;

    localparam int CAP           = CAPACITY_DEF;
    localparam int NUM_ROWS      = 20;
    localparam int RANDOM_ITEMS  = 190;
    localparam int PAUSE_AT      = 95;
    localparam int PHASE_LEN     = 40;
    localparam int DRAIN_CYCLES  = 80;
    // Final marks that would close the stream this close to the expected position are
    // held back until the closing sequence.
    localparam logic [IDX_W-1:0] CLOSE_GUARD = 64'd600;

    // One request on the input channel.
    typedef struct packed {
        logic [IDX_W-1:0]  stream_index;
        logic [BYTE_W-1:0] data_byte;
        logic              no_byte;
        logic              final_mark;
        logic [ROOM_W-1:0] room;
    } t_seg_req;

    // One result on the output channel.
    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] out_byte;
        logic              last_result;
        logic              stream_closed;
        logic [CNT_W-1:0]  pending_bytes;
    } t_seg_res;

    // A row of the directed table; the expected fields matter only where typed is set.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
        logic              empty;
        logic              fin;
        logic [ROOM_W-1:0] room;
        logic              typed;
        logic              has;
        logic [BYTE_W-1:0] value;
        logic              closed;
        logic [CNT_W-1:0]  held;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    bsr_in_if  req_ch ();
    bsr_out_if res_ch ();

    byte_stream_reassembler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // Predicted reassembly state.
    logic [BYTE_W-1:0] ring_bytes [CAP];
    logic              ring_held  [CAP];
    logic [IDX_W-1:0]  next_pos;
    logic [IDX_W-1:0]  end_pos;
    logic              end_known;
    logic [CNT_W-1:0]  held_cnt;
    logic              stream_done;

    t_seg_res expected_q [$];
    int       fail_count;
    bit       steady;

    // Directed requests: window edges, room extremes, duplicates, stale bytes, final marks.
    t_plan_row stimulus_plan [NUM_ROWS] = '{
        // Empty request with no room on a fresh stream.
        '{64'd0, 8'h00, 1'b1, 1'b0, 7'd0, 1'b1, 1'b0, 8'h00, 1'b0, 7'd0},
        // Zero room drops every byte.
        '{64'd5, 8'h5A, 1'b0, 1'b0, 7'd0, 1'b1, 1'b0, 8'h00, 1'b0, 7'd0},
        // Room above capacity is saturated; the byte is held awaiting earlier data.
        '{64'd3, 8'hFF, 1'b0, 1'b0, 7'd127, 1'b1, 1'b0, 8'h00, 1'b0, 7'd1},
        // One past the window is dropped.
        '{64'd64, 8'h77, 1'b0, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b0, 7'd1},
        // Last position of the window is kept.
        '{64'd63, 8'h00, 1'b0, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b0, 7'd2},
        // A second copy of a held byte loses.
        '{64'd3, 8'h11, 1'b0, 1'b0, 7'd64, 1'b1, 1'b0, 8'h00, 1'b0, 7'd2},
        // The expected byte is released at once.
        '{64'd0, 8'hAA, 1'b0, 1'b0, 7'd64, 1'b1, 1'b1, 8'hAA, 1'b0, 7'd2},
        '{64'd1, 8'h55, 1'b0, 1'b0, 7'd2, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        // Room runs out while the next byte is already held.
        '{64'd2, 8'h01, 1'b0, 1'b0, 7'd1, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        '{64'd0, 8'h00, 1'b1, 1'b0, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        // Stale byte.
        '{64'd2, 8'h33, 1'b0, 1'b0, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        // Final byte at the top index wraps the end position to zero.
        '{64'hFFFF_FFFF_FFFF_FFFF, 8'h99, 1'b0, 1'b1, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        // Later final marks overwrite the end position.
        '{64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 1'b1, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        '{64'd1000, 8'h00, 1'b1, 1'b1, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        '{64'd4, 8'hC3, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        // Build a run and release part of it, then the rest.
        '{64'd6, 8'h66, 1'b0, 1'b0, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        '{64'd5, 8'h5C, 1'b0, 1'b0, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        '{64'd7, 8'h80, 1'b0, 1'b0, 7'd64, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        '{64'd4, 8'h44, 1'b0, 1'b0, 7'd3, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0},
        '{64'd0, 8'h00, 1'b1, 1'b0, 7'd127, 1'b0, 1'b0, 8'h00, 1'b0, 7'd0}
    };

    // Store the byte of one request, release the contiguous run and queue the results.
    task automatic reassemble_step(input t_seg_req r);
        logic [IDX_W-1:0] offset;
        int unsigned      win;
        int unsigned      slot;
        int               first;
        t_seg_res         tail;
        first = expected_q.size();
        if (stream_done) begin
            expected_q.push_back('{1'b0, 8'h00, 1'b1, 1'b1, held_cnt});
            return;
        end
        win = (r.room > CAP) ? CAP : r.room;
        if (r.final_mark) begin
            end_pos   = r.no_byte ? r.stream_index : r.stream_index + 64'd1;
            end_known = 1'b1;
        end
        offset = r.stream_index - next_pos;
        if (!r.no_byte && r.stream_index >= next_pos && offset < IDX_W'(win)) begin
            slot = int'(r.stream_index % CAP);
            if (!ring_held[slot]) begin
                ring_held[slot]  = 1'b1;
                ring_bytes[slot] = r.data_byte;
                held_cnt++;
            end
        end
        // Release in order while room lasts.
        while (win > 0 && ring_held[int'(next_pos % CAP)]) begin
            slot = int'(next_pos % CAP);
            ring_held[slot] = 1'b0;
            held_cnt--;
            next_pos++;
            win--;
            expected_q.push_back('{1'b1, ring_bytes[slot], 1'b0, 1'b0, held_cnt});
        end
        if (end_known && next_pos == end_pos) begin
            stream_done = 1'b1;
        end
        if (expected_q.size() == first) begin
            expected_q.push_back('{1'b0, 8'h00, 1'b1, stream_done, held_cnt});
        end else begin
            tail = expected_q.pop_back();
            tail.last_result   = 1'b1;
            tail.stream_closed = stream_done;
            expected_q.push_back(tail);
        end
    endtask

    // Random request, mostly bytes near the expected position.
    function automatic t_seg_req random_request();
        t_seg_req         r;
        int unsigned      pick;
        logic [IDX_W-1:0] fin_pos;
        pick = $urandom_range(0, 99);
        r.data_byte = 8'($urandom);
        r.no_byte   = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
            r.room = 7'($urandom_range(0, 127));
        end else begin
            r.room = 7'($urandom_range(8, 64));
        end
        if (pick < 60) begin
            if ($urandom_range(0, 4) == 0) begin
                r.stream_index = next_pos + 64'($urandom_range(25, 63));
            end else begin
                r.stream_index = next_pos + 64'($urandom_range(0, 24));
            end
        end else if (pick < 72) begin
            r.stream_index = next_pos;
        end else if (pick < 82) begin
            // Behind the expected position, or wrapped far ahead near the start.
            r.stream_index = next_pos - 64'($urandom_range(1, 70));
        end else if (pick < 90) begin
            r.stream_index = {$urandom, $urandom};
        end else begin
            r.no_byte = 1'b1;
            if ($urandom_range(0, 1) == 0) begin
                r.stream_index = {$urandom, $urandom};
            end else begin
                r.stream_index = next_pos + 64'($urandom_range(0, 5000));
            end
        end
        r.final_mark = ($urandom_range(0, 9) == 0);
        fin_pos = r.no_byte ? r.stream_index : r.stream_index + 64'd1;
        if (fin_pos - next_pos <= CLOSE_GUARD) begin
            r.final_mark = 1'b0;
        end
        return r;
    endfunction

    // Sender idle cycles after a request: mostly none, a few long.
    function automatic int sender_gap();
        int unsigned p;
        if (steady) begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return 0;
        end
        if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 20);
    endfunction

    // Drive one request from a falling edge, predict on acceptance, then idle for the given gap.
    task automatic push_request(input t_seg_req r, input bit typed, input t_seg_res want,
                                input int gap);
        req_ch.valid        <= 1'b1;
        req_ch.stream_index <= r.stream_index;
        req_ch.data_byte    <= r.data_byte;
        req_ch.no_byte      <= r.no_byte;
        req_ch.final_mark   <= r.final_mark;
        req_ch.room         <= r.room;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        reassemble_step(r);
        // A typed row stands in for the single predicted result.
        if (typed) begin
            void'(expected_q.pop_back());
            expected_q.push_back(want);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #25ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, with stretches of steady ready.
    initial begin
        int stall;
        int unsigned p;
        stall = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady) begin
                res_ch.ready <= 1'b1;
            end else if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
                p = $urandom_range(0, 99);
                if (p < 70) begin
                    stall = 0;
                end else if (p < 95) begin
                    stall = $urandom_range(1, 3);
                end else begin
                    stall = $urandom_range(8, 20);
                end
            end
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge i_clk) begin
        t_seg_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: has_byte %0d out_byte %0h",
                       res_ch.has_byte, res_ch.out_byte);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                compare_field("has_byte", 8'(want.has_byte), 8'(res_ch.has_byte));
                compare_field("out_byte", want.out_byte, res_ch.out_byte);
                compare_field("last_result", 8'(want.last_result), 8'(res_ch.last_result));
                compare_field("stream_closed", 8'(want.stream_closed),
                              8'(res_ch.stream_closed));
                compare_field("pending_bytes", 8'(want.pending_bytes),
                              8'(res_ch.pending_bytes));
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        t_seg_req r;
        t_plan_row row;
        int n;
        fail_count  = 0;
        steady      = 1'b0;
        next_pos    = '0;
        end_pos     = '0;
        end_known   = 1'b0;
        held_cnt    = '0;
        stream_done = 1'b0;
        foreach (ring_held[k]) begin
            ring_held[k]  = 1'b0;
            ring_bytes[k] = '0;
        end
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.stream_index = '0;
        req_ch.data_byte    = '0;
        req_ch.no_byte      = 1'b0;
        req_ch.final_mark   = 1'b0;
        req_ch.room         = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (stimulus_plan[k]) begin
            row = stimulus_plan[k];
            push_request('{row.idx, row.data, row.empty, row.fin, row.room}, row.typed,
                         '{row.has, row.value, 1'b1, row.closed, row.held}, sender_gap());
        end

        // Random requests in phases; some phases run without idling on either side.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            if (n == PAUSE_AT) begin
                push_request(random_request(), 1'b0, '0, 1);
                while (expected_q.size() != 0) begin
                    @(negedge i_clk);
                end
            end else begin
                push_request(random_request(), 1'b0, '0, sender_gap());
            end
        end

        // Fill the holes until nothing is held.
        steady = 1'b0;
        while (held_cnt != 0) begin
            r = '{next_pos, 8'($urandom), 1'b0, 1'b0, 7'd64};
            push_request(r, 1'b0, '0, sender_gap());
        end
        // Final byte one past the expected one, then the expected byte closes the stream
        // exactly as the room runs out.
        r = '{next_pos + 64'd1, 8'($urandom), 1'b0, 1'b1, 7'd64};
        push_request(r, 1'b0, '0, sender_gap());
        r = '{next_pos, 8'($urandom), 1'b0, 1'b0, 7'd2};
        push_request(r, 1'b0, '0, sender_gap());
        // Requests after close are ignored.
        r = '{next_pos, 8'($urandom), 1'b1, 1'b1, 7'd64};
        push_request(r, 1'b0, '0, sender_gap());
        push_request(random_request(), 1'b0, '0, sender_gap());
        r = '{next_pos, 8'($urandom), 1'b0, 1'b0, 7'd64};
        push_request(r, 1'b0, '0, 0);
        req_ch.valid <= 1'b0;

        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bsr_pkg.sv
hdl/bsr_if.sv
hdl/bsr_ctrl.sv
hdl/bsr_datapath.sv
hdl/byte_stream_reassembler.sv
tb/sv/byte_stream_reassembler_tb.sv
